>>> sv/gfe_pkg.sv
// shared types, codes and constants of the 3x3 gray filter engine
package gfe_pkg;

  localparam int GFE_MAX_WIDTH  = 1024;
  localparam int GFE_MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;

  // filter modes
  localparam logic [2:0] MODE_SMOOTH  = 3'd0;
  localparam logic [2:0] MODE_INVERT  = 3'd1;
  localparam logic [2:0] MODE_EDGE    = 3'd2;
  localparam logic [2:0] MODE_SHARPEN = 3'd3;
  localparam logic [2:0] MODE_COPY    = 3'd4;

  // register indexes
  localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MAX_GRAY     = 2'd3;

  // which result of an input item is being produced
  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_BOTTOM = 2'd2;
  localparam logic [1:0] KIND_CORNER = 2'd3;

  // ceil(2^16 / 9), exact for dividends below 32768
  localparam logic [12:0] DIV9_RECIP = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  typedef struct packed {
    logic [2:0]       filter_mode;
    logic [10:0]      image_width;
    logic [10:0]      image_height;
    logic [PIX_W-1:0] max_gray;
  } gfe_cfg_t;

  // window column-major: win[col*3+row], centre win[4]
  typedef struct packed {
    logic                  valid;
    logic                  has_out;
    logic                  border;
    logic                  last_col;
    logic                  last_row;
    logic [8:0][PIX_W-1:0] win;
  } gfe_item_t;

endpackage

>>> sv/gfe_cfg_regs.sv
// register file of the filter engine behind an apb-style port
module gfe_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gfe_pkg::gfe_cfg_t cfg_o,
  output logic              restart_o
);
  import gfe_pkg::*;

  gfe_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        REG_FILTER_MODE: cfg_d.filter_mode = pwdata[2:0];
        REG_IMAGE_WIDTH: begin
          cfg_d.image_width = pwdata[10:0];
          restart_o         = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          cfg_d.image_height = pwdata[10:0];
          restart_o          = 1'b1;
        end
        default: cfg_d.max_gray = pwdata[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode  <= MODE_SMOOTH;
      cfg_q.image_width  <= 11'd1024;
      cfg_q.image_height <= 11'd1024;
      cfg_q.max_gray     <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_MODE:  prdata = {29'd0, cfg_q.filter_mode};
      REG_IMAGE_WIDTH:  prdata = {21'd0, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {21'd0, cfg_q.image_height};
      default:          prdata = {24'd0, cfg_q.max_gray};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/gfe_line_buf.sv
// raster counters, two line memories, window registers and the input register
module gfe_line_buf #(
  parameter int MAX_WIDTH  = gfe_pkg::GFE_MAX_WIDTH,
  parameter int MAX_HEIGHT = gfe_pkg::GFE_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gfe_pkg::gfe_cfg_t  cfg_i,
  input  logic               restart_i,
  input  logic               accept_i,
  input  logic [7:0]         pixel_i,
  input  logic               retire_i,
  output gfe_pkg::gfe_item_t item_o,
  output logic [RW-1:0]      row_o,
  output logic [CW-1:0]      col_o
);
  import gfe_pkg::*;

  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];

  logic [CW-1:0] c_cnt_q, c_cnt_d, c_q, w_last;
  logic [RW-1:0] r_cnt_q, r_cnt_d, r_q, h_last;
  logic          valid_q;
  logic          lc, lr;
  logic          lc_q, lr_q, has_q, border_q;
  logic [5:0][PIX_W-1:0] wreg_q;
  logic [PIX_W-1:0] p_q, top_q, mid_q;

  // clamp the programmed size into 3..max
  always_comb begin
    if (cfg_i.image_width < 11'd3) begin
      w_last = CW'(2);
    end else if ({21'd0, cfg_i.image_width} > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(cfg_i.image_width - 11'd1);
    end
    if (cfg_i.image_height < 11'd3) begin
      h_last = RW'(2);
    end else if ({21'd0, cfg_i.image_height} > 32'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(cfg_i.image_height - 11'd1);
    end
  end

  assign lc = (c_cnt_q == w_last);
  assign lr = (r_cnt_q == h_last);

  always_comb begin
    c_cnt_d = c_cnt_q;
    r_cnt_d = r_cnt_q;
    if (restart_i) begin
      c_cnt_d = '0;
      r_cnt_d = '0;
    end else if (accept_i) begin
      if (lc) begin
        c_cnt_d = '0;
        r_cnt_d = lr ? '0 : r_cnt_q + RW'(1);
      end else begin
        c_cnt_d = c_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_cnt_q <= '0;
      r_cnt_q <= '0;
      valid_q <= 1'b0;
      wreg_q  <= '0;
    end else begin
      c_cnt_q <= c_cnt_d;
      r_cnt_q <= r_cnt_d;
      if (accept_i) begin
        valid_q <= 1'b1;
      end else if (retire_i) begin
        valid_q <= 1'b0;
      end
      if (retire_i) begin
        wreg_q <= {p_q, mid_q, top_q, wreg_q[5:3]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p_q      <= pixel_i;
      r_q      <= r_cnt_q;
      c_q      <= c_cnt_q;
      lc_q     <= lc;
      lr_q     <= lr;
      has_q    <= (r_cnt_q != '0) && (c_cnt_q != '0);
      border_q <= (r_cnt_q < RW'(2)) || (c_cnt_q < CW'(2));
    end
  end

  // write-back of the retiring item never hits the address read for the next one
  always_ff @(posedge clk_i) begin
    if (retire_i) begin
      line_a[c_q] <= p_q;
      line_b[c_q] <= mid_q;
    end
    if (accept_i) begin
      top_q <= line_b[c_cnt_q];
      mid_q <= line_a[c_cnt_q];
    end
  end

  always_comb begin
    item_o.valid    = valid_q;
    item_o.has_out  = has_q;
    item_o.border   = border_q;
    item_o.last_col = lc_q;
    item_o.last_row = lr_q;
    item_o.win      = {p_q, mid_q, top_q, wreg_q};
  end

  assign row_o = r_q;
  assign col_o = c_q;

endmodule

>>> sv/gfe_kernel.sv
// per-result pixel arithmetic: box mean, laplace, sharpen, invert, copy
module gfe_kernel (
  input  gfe_pkg::gfe_cfg_t  cfg_i,
  input  gfe_pkg::gfe_item_t item_i,
  input  logic [1:0]         kind_i,
  output logic [7:0]         value_o
);
  import gfe_pkg::*;

  logic [PIX_W-1:0]  src;
  logic              border;
  logic [11:0]       sum9;
  logic signed [11:0] lap;
  logic [11:0]       lap_abs;
  logic [11:0]       dividend;
  logic [24:0]       prod;
  logic [7:0]        quot;
  logic signed [13:0] sharp;
  logic [7:0]        sharp_clip;
  logic [7:0]        inv;

  always_comb begin
    case (kind_i)
      KIND_CENTER: src = item_i.win[4];
      KIND_RIGHT:  src = item_i.win[7];
      KIND_BOTTOM: src = item_i.win[5];
      default:     src = item_i.win[8];
    endcase
  end

  assign border = (kind_i != KIND_CENTER) || item_i.border;

  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 9; k++) begin
      sum9 = sum9 + 12'(item_i.win[k]);
    end
  end

  assign lap = $signed({2'b00, item_i.win[4], 2'b00})
             - $signed({4'd0, item_i.win[1]}) - $signed({4'd0, item_i.win[3]})
             - $signed({4'd0, item_i.win[5]}) - $signed({4'd0, item_i.win[7]});
  assign lap_abs = lap[11] ? 12'(-lap) : 12'(lap);

  // one shared reciprocal multiply for both /9 modes
  assign dividend = (cfg_i.filter_mode == MODE_EDGE) ? lap_abs : sum9;
  assign prod     = 25'(dividend) * 25'(DIV9_RECIP);
  assign quot     = prod[DIV9_SHIFT +: 8];

  // 10c - sum9 is 9c minus the eight neighbours
  assign sharp = $signed(14'({item_i.win[4], 3'b000}) + 14'({item_i.win[4], 1'b0}))
               - $signed(14'(sum9));

  always_comb begin
    if (sharp < 14'sd0) begin
      sharp_clip = '0;
    end else if (sharp > $signed({6'd0, cfg_i.max_gray})) begin
      sharp_clip = cfg_i.max_gray;
    end else begin
      sharp_clip = sharp[7:0];
    end
  end

  assign inv = (src > cfg_i.max_gray) ? 8'd0 : cfg_i.max_gray - src;

  always_comb begin
    case (cfg_i.filter_mode)
      MODE_SMOOTH:  value_o = border ? 8'd0 : quot;
      MODE_INVERT:  value_o = inv;
      MODE_EDGE:    value_o = border ? 8'd0 : quot;
      MODE_SHARPEN: value_o = border ? 8'd0 : sharp_clip;
      default:      value_o = src;
    endcase
  end

endmodule

>>> sv/gray_3x3_filter_engine.sv
// top level of the 3x3 gray filter engine: result sequencer and output register
//
// Pixels enter in raster order on the s_axis stream, one request per pixel.
// Results leave on the m_axis stream; each carries the filtered value and
// its row and column, tlast marks the last result caused by one pixel and
// tuser marks the final result of the image.
// A pixel stays in the input register until it has issued all results it causes
// (none in the first row and column, one in the interior, up to four at the right
// edge of the last row), so interior pixels flow at one per cycle while the
// receiver takes results; results leave through the output register, and row ends
// and the last row slow the input, as the single result port takes one at a time.
// When the receiver stalls, the current result waits in the output register
// while one more pixel can be taken; then tready falls until results drain.
// Reset clears counters, window registers and the register file (smooth,
// 1024 x 1024, max gray 255); the line memories are not cleared, since their
// contents are only used after the rows above have been written.
// Registers are to be written over the apb-style port only while the stream is
// idle; the user is bound to this, as the block itself does not enforce it.
module gray_3x3_filter_engine #(
  parameter int MAX_WIDTH  = gfe_pkg::GFE_MAX_WIDTH,
  parameter int MAX_HEIGHT = gfe_pkg::GFE_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] pixel_out, [17:8] out_row, [27:18] out_col
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gfe_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  gfe_cfg_t  cfg;
  gfe_item_t item;
  logic          restart;
  logic [RW-1:0] row;
  logic [CW-1:0] col;

  logic       accept, retire, emit, is_last, out_free;
  logic [1:0] idx_q, idx_d, last_idx, kind;
  logic [7:0] value;
  logic [RW-1:0] res_row;
  logic [CW-1:0] res_col;

  logic         out_valid_q;
  logic [7:0]   out_pix_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;
  logic         out_last_q, out_done_q;

  gfe_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  gfe_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .accept_i  (accept),
    .pixel_i   (s_axis_tdata),
    .retire_i  (retire),
    .item_o    (item),
    .row_o     (row),
    .col_o     (col)
  );

  // results of one pixel: centre, right edge, bottom edge, corner
  assign last_idx = {item.last_col & item.last_row, item.last_col | item.last_row};
  assign is_last  = (idx_q == last_idx);

  always_comb begin
    case (idx_q)
      2'd0:    kind = KIND_CENTER;
      2'd1:    kind = item.last_col ? KIND_RIGHT : KIND_BOTTOM;
      2'd2:    kind = KIND_BOTTOM;
      default: kind = KIND_CORNER;
    endcase
  end

  gfe_kernel u_kernel (
    .cfg_i   (cfg),
    .item_i  (item),
    .kind_i  (kind),
    .value_o (value)
  );

  assign res_row = (kind == KIND_CENTER || kind == KIND_RIGHT) ? row - RW'(1) : row;
  assign res_col = (kind == KIND_CENTER || kind == KIND_BOTTOM) ? col - CW'(1) : col;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = item.valid && item.has_out && out_free;
  assign retire        = item.valid && (!item.has_out || (emit && is_last));
  assign s_axis_tready = !item.valid || retire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q  <= value;
      out_row_q  <= COORD_W'(res_row);
      out_col_q  <= COORD_W'(res_col);
      out_last_q <= is_last;
      out_done_q <= (kind == KIND_CORNER);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_col_q, out_row_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  // sequencer only runs while a pixel is held
  a_idx_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> item.valid)
    else $error("result index set without a held pixel");

  // end of image is always the last result of its pixel
  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame_done without tlast");

  // a pixel with more results stays and advances the index
  a_idx_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !is_last |=> item.valid && idx_q == 2'($past(idx_q) + 2'd1))
    else $error("pixel left before all its results");

  // a stalled receiver blocks a pixel that still owes results
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && item.valid && item.has_out |-> !s_axis_tready)
    else $error("input taken while results are stalled");

endmodule

>>> bench/gray_3x3_filter_engine_tb.sv
// self-checking testbench of the 3x3 gray filter engine: stream, register port and result checks
module gray_3x3_filter_engine_tb;
  import gfe_pkg::*;

  localparam int LIMIT_CYCLES  = 200_000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 290;
  localparam int MAX_REPORTS   = 40;

  // unused mode code, behaves like copy
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [7:0] pix;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
    logic       done;
  } filt_result_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_BURSTY} rx_style_e;

  // predicts the filtered pixels of each request and checks them in order
  class window_predictor;
    logic [2:0]   mode;
    logic [10:0]  width_raw;
    logic [10:0]  height_raw;
    logic [7:0]   gray_max;
    logic [7:0]   line_near [GFE_MAX_WIDTH];
    logic [7:0]   line_far  [GFE_MAX_WIDTH];
    logic [7:0]   taps [6];
    logic [7:0]   win [9];
    int unsigned  row_at;
    int unsigned  col_at;
    filt_result_t due [$];
    int           errors;
    int           pixels;
    int           results;
    int           images;

    function new();
      mode       = MODE_SMOOTH;
      width_raw  = 11'(GFE_MAX_WIDTH);
      height_raw = 11'(GFE_MAX_HEIGHT);
      gray_max   = 8'hFF;
      foreach (line_near[i]) begin
        line_near[i] = '0;
        line_far[i]  = '0;
      end
      foreach (taps[i]) taps[i] = '0;
      row_at  = 0;
      col_at  = 0;
      errors  = 0;
      pixels  = 0;
      results = 0;
      images  = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    function int unsigned fit_size(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return fit_size(width_raw, GFE_MAX_WIDTH);
    endfunction

    function int unsigned rows();
      return fit_size(height_raw, GFE_MAX_HEIGHT);
    endfunction

    function int unsigned left_in_image();
      return cols() * rows() - (row_at * cols() + col_at);
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void load_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_FILTER_MODE: mode = value[2:0];
        REG_IMAGE_WIDTH: begin
          width_raw = value[10:0];
          row_at    = 0;
          col_at    = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_raw = value[10:0];
          row_at     = 0;
          col_at     = 0;
        end
        REG_MAX_GRAY: gray_max = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [1:0] idx);
      case (idx)
        REG_FILTER_MODE:  return {29'd0, mode};
        REG_IMAGE_WIDTH:  return {21'd0, width_raw};
        REG_IMAGE_HEIGHT: return {21'd0, height_raw};
        default:          return {24'd0, gray_max};
      endcase
    endfunction

    function logic [7:0] interior();
      int sum;
      int ctr;
      int v;
      sum = 0;
      ctr = int'(win[4]);
      for (int k = 0; k < 9; k++) sum += int'(win[k]);
      case (mode)
        MODE_SMOOTH: return 8'(sum / 9);
        MODE_EDGE: begin
          v = 4 * ctr - int'(win[3]) - int'(win[1]) - int'(win[5]) - int'(win[7]);
          v = v / 9;
          if (v < 0) v = -v;
          return 8'(v);
        end
        MODE_SHARPEN: begin
          v = 10 * ctr - sum;
          if (v < 0) v = 0;
          if (v > int'(gray_max)) v = int'(gray_max);
          return 8'(v);
        end
        default: return '0;
      endcase
    endfunction

    function logic [7:0] point(logic [7:0] p, bit border);
      case (mode)
        MODE_INVERT: return (p > gray_max) ? 8'd0 : gray_max - p;
        MODE_SMOOTH, MODE_EDGE, MODE_SHARPEN: return border ? 8'd0 : interior();
        default: return p;
      endcase
    endfunction

    function filt_result_t place(logic [7:0] v, int unsigned r, int unsigned c);
      filt_result_t res;
      res.pix  = v;
      res.row  = 10'(r);
      res.col  = 10'(c);
      res.last = 1'b0;
      res.done = 1'b0;
      return res;
    endfunction

    function void note_pixel(logic [7:0] px);
      int unsigned  w;
      int unsigned  h;
      int unsigned  r;
      int unsigned  c;
      logic [7:0]   top;
      logic [7:0]   mid;
      bit           last_col;
      bit           last_row;
      filt_result_t res [4];
      int           n;
      w = cols();
      h = rows();
      r = row_at;
      c = col_at;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      top      = line_far[c];
      mid      = line_near[c];
      last_col = (c == w - 1);
      last_row = (r == h - 1);
      for (int k = 0; k < 6; k++) win[k] = taps[k];
      win[6] = top;
      win[7] = mid;
      win[8] = px;
      n = 0;
      if (r >= 1 && c >= 1) begin
        res[n] = place(point(win[4], !(r >= 2 && c >= 2)), r - 1, c - 1);
        n++;
        // right border of the row above, then bottom border and the final corner
        if (last_col) begin
          res[n] = place(point(mid, 1'b1), r - 1, c);
          n++;
        end
        if (last_row) begin
          res[n] = place(point(win[5], 1'b1), r, c - 1);
          n++;
        end
        if (last_col && last_row) begin
          res[n] = place(point(px, 1'b1), r, c);
          res[n].done = 1'b1;
          n++;
        end
        res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) due.push_back(res[k]);
      end
      line_far[c]  = mid;
      line_near[c] = px;
      taps[0] = taps[3];
      taps[1] = taps[4];
      taps[2] = taps[5];
      taps[3] = top;
      taps[4] = mid;
      taps[5] = px;
      if (last_col) begin
        col_at = 0;
        row_at = last_row ? 0 : r + 1;
      end else begin
        col_at = c + 1;
        row_at = r;
      end
      pixels++;
    endfunction

    task check_result(logic [31:0] word, logic last, logic done);
      filt_result_t want;
      results++;
      if (word[31:28] !== 4'd0)
        report($sformatf("padding bits of result are %0h", word[31:28]));
      if (due.size() == 0) begin
        report($sformatf("result at row %0d col %0d with none due", word[17:8], word[27:18]));
        return;
      end
      want = due.pop_front();
      if (word[7:0] !== want.pix)
        report($sformatf("pixel at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, word[7:0], want.pix));
      if (word[17:8] !== want.row)
        report($sformatf("row: got %0d, want %0d", word[17:8], want.row));
      if (word[27:18] !== want.col)
        report($sformatf("col: got %0d, want %0d", word[27:18], want.col));
      if (last !== want.last)
        report($sformatf("tlast at (%0d,%0d): got %b", want.row, want.col, last));
      if (done !== want.done)
        report($sformatf("tuser at (%0d,%0d): got %b", want.row, want.col, done));
      if (want.done) images++;
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;   // [7:0] pixel_in
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [31:0] m_axis_tdata;          // [7:0] pixel_out, [17:8] out_row, [27:18] out_col
  logic        m_axis_tlast;
  logic        m_axis_tuser;          // [0] frame_done
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [3:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  window_predictor board = new();

  rx_style_e rx_style      = RX_ALWAYS;
  bit        tx_gaps       = 1'b0;
  bit        hold_off_req  = 1'b0;
  int        burst_left    = 0;

  // handshakes seen just before each rising edge
  logic        pix_taken = 1'b0;
  logic [7:0]  pix_seen  = '0;
  logic        res_taken = 1'b0;
  logic [31:0] res_word  = '0;
  logic        res_last  = 1'b0;
  logic        res_done  = 1'b0;

  gray_3x3_filter_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pix_taken = (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
    pix_seen  = s_axis_tdata;
    res_taken = (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
    res_word  = m_axis_tdata;
    res_last  = m_axis_tlast;
    res_done  = m_axis_tuser;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (pix_taken) board.note_pixel(pix_seen);
      if (res_taken) board.check_result(res_word, res_last, res_done);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout with %0d results outstanding", board.pending());
    $display("** gray_3x3_filter_engine: FAILED **");
    $finish;
  end

  // result side: steady, coin-toss or bursty stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_run;
    int ready_run;
    stall_run = 0;
    ready_run = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        case (rx_style)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_run > 0) begin
              stall_run--;
              m_axis_tready <= 1'b0;
            end else if (ready_run > 0) begin
              ready_run--;
              m_axis_tready <= 1'b1;
            end else begin
              ready_run = $urandom_range(1, 16);
              stall_run = $urandom_range(1, 8);
              m_axis_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done  = (pready === 1'b1);
      rdata = prdata;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== board.register_value(idx))
      board.report($sformatf("register %0d reads %0h, want %0h",
                             idx, rd, board.register_value(idx)));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(idx, 1'b1, value, rd);
    board.load_register(idx, value);
    check_register(idx);
  endtask

  // one pixel request; the sender runs in bursts, with random gaps between them when tx_gaps is set
  task automatic push_pixel(input logic [7:0] px);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (s_axis_tready === 1'b1);
      @(posedge clk_i);
    end
  endtask

  task automatic send_list(input logic [7:0] px [$]);
    foreach (px[i]) push_pixel(px[i]);
  endtask

  // stream idle, all due results in, then a settling wait for pixels that emit nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] next_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return board.gray_max;
      3: return board.gray_max + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [7:0]  pat [$];
    logic [1:0]  reg_list [4];
    int          n;
    int          random_sent;
    bit          held;
    bit          first;
    logic [31:0] gray;
    reg_list = '{REG_FILTER_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_MAX_GRAY};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (reg_list[i]) check_register(reg_list[i]);

    // sizes below the minimum give a 3x3 image; sharpen clamps at the top
    write_reg(REG_IMAGE_WIDTH, 32'd2);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    write_reg(REG_FILTER_MODE, 32'(MODE_SHARPEN));
    write_reg(REG_MAX_GRAY, 32'd200);
    pat = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    send_list(pat);
    settle();

    // edge with a negative sum, truncated toward zero
    write_reg(REG_FILTER_MODE, 32'(MODE_EDGE));
    pat = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    send_list(pat);
    settle();

    // one image, modes switched between pixels: invert saturating, spare code, smooth
    write_reg(REG_FILTER_MODE, 32'(MODE_INVERT));
    write_reg(REG_MAX_GRAY, 32'd1);
    pat = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd1};
    send_list(pat);
    settle();
    write_reg(REG_FILTER_MODE, 32'(MODE_SPARE_HI));
    pat = '{8'd128, 8'd0};
    send_list(pat);
    settle();
    write_reg(REG_FILTER_MODE, 32'(MODE_SMOOTH));
    pat = '{8'd254, 8'd255};
    send_list(pat);
    settle();

    // height above the limit is clamped; narrow rows keep the run short
    rx_style = RX_COIN;
    tx_gaps  = 1'b1;
    write_reg(REG_MAX_GRAY, 32'd255);
    write_reg(REG_FILTER_MODE, $urandom_range(0, 7));
    write_reg(REG_IMAGE_WIDTH, 32'd3);
    write_reg(REG_IMAGE_HEIGHT, 32'd1500);
    repeat (24) push_pixel(next_pixel());
    settle();
    rx_style = RX_BURSTY;

    // small images with random settings, mostly whole images
    random_sent = 0;
    held  = 1'b0;
    first = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 2) == 0) begin
        write_reg(REG_IMAGE_WIDTH,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9));
        write_reg(REG_IMAGE_HEIGHT,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6));
        first = 1'b0;
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_FILTER_MODE, $urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       gray = 32'd1;
          1:       gray = 32'd255;
          default: gray = $urandom_range(1, 255);
        endcase
        write_reg(REG_MAX_GRAY, gray);
      end
      rx_style = rx_style_e'($urandom_range(0, 2));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        n = board.left_in_image();
        if ($urandom_range(0, 2) == 0) n += board.cols() * board.rows();
      end else begin
        n = $urandom_range(1, board.cols() * board.rows());
      end
      // long receiver hold-off while pixels keep coming, so the input backs up
      if (!held && random_sent >= 120) begin
        held = 1'b1;
        hold_off_req = 1'b1;
        if (n < 30) n = 30;
      end
      repeat (n) push_pixel(next_pixel());
      random_sent += n;
      settle();
    end

    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    $display("covered %0d pixels and %0d results over %0d whole images in all modes,",
             board.pixels, board.results, board.images);
    $display("sizes clamped below 3 and above 1024, with bursty input and stalled output");
    if (board.errors == 0) begin
      $display("** gray_3x3_filter_engine: PASSED **");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("** gray_3x3_filter_engine: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gfe_pkg.sv
sv/gfe_cfg_regs.sv
sv/gfe_line_buf.sv
sv/gfe_kernel.sv
sv/gray_3x3_filter_engine.sv
bench/gray_3x3_filter_engine_tb.sv
